// ===== hw/rtl/pcps_pkg.sv =====
// ----------------------------------------------------------------------------
// pcps_pkg
// shared constants, codes and control types of the pulse-coupled period sync
// ----------------------------------------------------------------------------
`default_nettype none

package pcps_pkg;

  // tick counter width, legal from 16 to 64
  localparam int unsigned CntW = 32;

  localparam int unsigned PeriodW  = 8;
  localparam int unsigned DividerW = 10;
  localparam int unsigned CapW     = 8;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned PhaseW   = 8;
  localparam int unsigned AccW     = 32;

  localparam int unsigned DivW    = 32;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic [PeriodW-1:0]  PeriodReset  = 8'd50;
  localparam logic [DividerW-1:0] DividerReset = 10'd120;
  localparam logic [CapW-1:0]     CapReset     = 8'd30;
  localparam int unsigned         PhaseLimit   = 255;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_PERIOD  = 2'd0,
    CFG_DIVIDER = 2'd1,
    CFG_CAP     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_TICK     = 1'b0,
    OP_NEIGHBOR = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_DIV,
    S_APPLY,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic start_div;
    logic finish_direct;
    logic finish_div;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic div_done;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcps_divider.sv =====
// ----------------------------------------------------------------------------
// pcps_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pcps_divider (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [pcps_pkg::DivW-1:0]           dividend_i,
  input  wire logic [pcps_pkg::DividerW-1:0]       divisor_i,
  output logic                                     busy_o,
  output logic                                     done_o,
  output logic [pcps_pkg::DivW-1:0]                quot_o,
  output logic [pcps_pkg::DividerW-1:0]            rem_o
);

  localparam int unsigned DivW    = pcps_pkg::DivW;
  localparam int unsigned DvsW    = pcps_pkg::DividerW;
  localparam int unsigned DivCntW = pcps_pkg::DivCntW;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]     quo_q, quo_d;
  logic [DvsW-1:0]     rem_q, rem_d;
  logic [DvsW-1:0]     dvs_q, dvs_d;
  logic [DvsW:0]       trial;
  logic [DvsW:0]       diff;
  logic                fits;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DivW-2:0], fits};
      rem_d = fits ? diff[DvsW-1:0] : trial[DvsW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pcps_datapath.sv =====
// ----------------------------------------------------------------------------
// pcps_datapath
// counters, correction accumulator, phase folding and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pcps_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pcps_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  wire logic [pcps_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                               in_op_i,
  input  wire logic [pcps_pkg::PhaseW-1:0]        in_neighbor_phase_i,
  input  wire pcps_pkg::ctrl_cmd_t                cmd_i,
  output pcps_pkg::ctrl_status_t                  status_o,
  output logic                                    flash_o,
  output logic [pcps_pkg::PhaseW-1:0]             own_phase_o,
  output logic                                    phase_valid_o
);

  localparam int unsigned CntW  = pcps_pkg::CntW;
  localparam int unsigned AccW  = pcps_pkg::AccW;
  localparam int unsigned PerW  = pcps_pkg::PeriodW;
  localparam int unsigned DvsW  = pcps_pkg::DividerW;
  localparam int unsigned CapW  = pcps_pkg::CapW;
  localparam int unsigned PhW   = pcps_pkg::PhaseW;
  localparam int unsigned DivW  = pcps_pkg::DivW;
  localparam int unsigned DW    = AccW + 2;

  // configuration
  logic [PerW-1:0] period_q;
  logic [DvsW-1:0] divider_q;
  logic [CapW-1:0] cap_q;

  // timer state
  logic [CntW-1:0] tick_count_q, tick_count_d;
  logic [CntW-1:0] next_reset_q, next_reset_d;
  logic [CntW-1:0] last_reset_q, last_reset_d;
  logic [AccW-1:0] accum_q, accum_d;
  logic            flash_on_q, flash_on_d;

  // transaction and folding registers
  logic            op_q;
  logic [PhW-1:0]  nb_q;
  logic [AccW-1:0] direct_adj_q;
  logic            need_rem_q;
  logic            x_neg_q;
  logic [DivW-1:0] x_mag_q;

  // result register
  logic            flash_q;
  logic [PhW-1:0]  own_phase_q;
  logic            phase_valid_q;

  // phase folding
  logic [CntW-1:0] elapsed;
  logic [AccW-1:0] e32;
  logic [DW-1:0]   d;
  logic [DW-1:0]   d_abs;
  logic [DW-1:0]   half;
  logic [DW-1:0]   p_ext;
  logic [DW-1:0]   x;
  logic [DW-1:0]   x_abs;
  logic            d_zero;
  logic            d_pos;
  logic            d_neg;
  logic            d_short;

  // divider hookup
  logic            div_busy;
  logic            div_done;
  logic [DivW-1:0] div_quot;
  logic [DvsW-1:0] div_rem;
  logic [DivW-1:0] div_dividend;
  logic [DvsW-1:0] div_divisor;
  logic [AccW-1:0] acc_abs;

  // correction and remainder
  logic [CapW-1:0] corr_mag;
  logic [CntW-1:0] corr;
  logic [AccW-1:0] rem_adj;
  logic            phase_ok;

  assign elapsed = tick_count_q - last_reset_q;
  assign e32     = AccW'(elapsed);
  assign d       = {{2{e32[AccW-1]}}, e32} - DW'(nb_q);
  assign d_zero  = (d == '0);
  assign d_neg   = d[DW-1];
  assign d_pos   = !d_neg && !d_zero;
  assign d_abs   = d_neg ? (~d + 1'b1) : d;
  assign half    = DW'(period_q[PerW-1:1]);
  assign p_ext   = DW'(period_q);
  assign d_short = d_abs < half;
  assign x       = d_pos ? (d - p_ext) : (d + p_ext);
  assign x_abs   = x[DW-1] ? (~x + 1'b1) : x;

  assign acc_abs      = accum_q[AccW-1] ? (~accum_q + 1'b1) : accum_q;
  assign div_dividend = (op_q == pcps_pkg::OP_TICK) ? DivW'(acc_abs) : x_mag_q;
  assign div_divisor  = (op_q == pcps_pkg::OP_TICK) ?
                        ((divider_q == '0) ? DvsW'(1) : divider_q) : DvsW'(period_q);

  pcps_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign corr_mag = (div_quot > DivW'(cap_q)) ? cap_q : div_quot[CapW-1:0];
  assign corr     = accum_q[AccW-1] ? (~CntW'(corr_mag) + 1'b1) : CntW'(corr_mag);
  assign rem_adj  = x_neg_q ? (~AccW'(div_rem[PerW-1:0]) + 1'b1) : AccW'(div_rem[PerW-1:0]);
  assign phase_ok = elapsed < CntW'(pcps_pkg::PhaseLimit);

  assign status_o.need_div = (op_q == pcps_pkg::OP_TICK) ? (tick_count_q >= next_reset_q)
                                                         : need_rem_q;
  assign status_o.div_busy = div_busy;
  assign status_o.div_done = div_done;

  always_comb begin
    tick_count_d = tick_count_q;
    next_reset_d = next_reset_q;
    last_reset_d = last_reset_q;
    accum_d      = accum_q;
    flash_on_d   = flash_on_q;
    if (cmd_i.prep && op_q == pcps_pkg::OP_TICK) begin
      tick_count_d = tick_count_q + 1'b1;
    end
    if (cmd_i.finish_direct) begin
      if (op_q == pcps_pkg::OP_TICK) begin
        if (tick_count_q > last_reset_q + 1'b1) begin
          flash_on_d = 1'b0;
        end
      end else begin
        accum_d = accum_q + direct_adj_q;
      end
    end
    if (cmd_i.finish_div) begin
      if (op_q == pcps_pkg::OP_TICK) begin
        last_reset_d = tick_count_q;
        next_reset_d = tick_count_q + CntW'(period_q) + corr;
        accum_d      = '0;
        flash_on_d   = 1'b1;
      end else begin
        accum_d = accum_q + rem_adj;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= pcps_pkg::PeriodReset;
      divider_q    <= pcps_pkg::DividerReset;
      cap_q        <= pcps_pkg::CapReset;
      tick_count_q <= '0;
      next_reset_q <= '0;
      last_reset_q <= '0;
      accum_q      <= '0;
      flash_on_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          pcps_pkg::CFG_PERIOD:  period_q  <= cfg_wdata_i[PerW-1:0];
          pcps_pkg::CFG_DIVIDER: divider_q <= cfg_wdata_i[DvsW-1:0];
          pcps_pkg::CFG_CAP:     cap_q     <= cfg_wdata_i[CapW-1:0];
          default: ;
        endcase
      end
      tick_count_q <= tick_count_d;
      next_reset_q <= next_reset_d;
      last_reset_q <= last_reset_d;
      accum_q      <= accum_d;
      flash_on_q   <= flash_on_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_op_i;
      nb_q <= in_neighbor_phase_i;
    end
    if (cmd_i.prep && op_q == pcps_pkg::OP_NEIGHBOR) begin
      direct_adj_q <= (d_short || d_zero) ? d[AccW-1:0] : x[AccW-1:0];
      need_rem_q   <= !d_short && !d_zero && (period_q != '0);
      x_neg_q      <= x[DW-1];
      x_mag_q      <= x_abs[DivW-1:0];
    end
    if (cmd_i.out_load) begin
      flash_q       <= flash_on_q;
      own_phase_q   <= phase_ok ? elapsed[PhW-1:0] : '0;
      phase_valid_q <= phase_ok;
    end
  end

  assign flash_o       = flash_q;
  assign own_phase_o   = own_phase_q;
  assign phase_valid_o = phase_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pcps_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcps_ctrl
// sequencer for one transaction: fetch, fold, divide and apply when needed, deliver
// ----------------------------------------------------------------------------
`default_nettype none

module pcps_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire pcps_pkg::ctrl_status_t status_i,
  output pcps_pkg::ctrl_cmd_t         cmd_o
);

  pcps_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pcps_pkg::S_IDLE:  if (in_valid_i) state_d = pcps_pkg::S_PREP;
      pcps_pkg::S_PREP:  state_d = pcps_pkg::S_CHECK;
      pcps_pkg::S_CHECK: state_d = status_i.need_div ? pcps_pkg::S_DIV : pcps_pkg::S_OUT;
      pcps_pkg::S_DIV:   if (status_i.div_done) state_d = pcps_pkg::S_APPLY;
      pcps_pkg::S_APPLY: state_d = pcps_pkg::S_OUT;
      pcps_pkg::S_OUT:   if (out_free) state_d = pcps_pkg::S_IDLE;
      default:           state_d = pcps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pcps_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pcps_pkg::S_PREP:  cmd_o.prep = 1'b1;
      pcps_pkg::S_CHECK: begin
        cmd_o.start_div     = status_i.need_div;
        cmd_o.finish_direct = !status_i.need_div;
      end
      pcps_pkg::S_APPLY: cmd_o.finish_div = 1'b1;
      pcps_pkg::S_OUT:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcps_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pcps_pkg::S_DIV |-> status_i.div_busy || status_i.div_done)
    else $error("waiting on divider that is not running");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_div |=> status_i.div_busy)
    else $error("divider did not start");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status_i.div_busy)
    else $error("divider busy while taking a new transaction");

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == pcps_pkg::S_PREP)
    else $error("accepted transaction not processed");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result loaded but not presented");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pulse_coupled_period_sync_top.sv =====
// ----------------------------------------------------------------------------
// pulse_coupled_period_sync_top
// firefly-style period timer that pulls its reset phase toward its neighbors
// ----------------------------------------------------------------------------
// channel   handshake                fields
// cfg       cfg_we_i                 cfg_addr_i, cfg_wdata_i
// in        in_valid_i / in_ready_o  in_op_i, in_neighbor_phase_i
// out       out_valid_o / out_ready_i out_flash_o, out_own_phase_o,
//                                    out_phase_valid_o
//
// a tick or a neighbor transaction without division goes from acceptance
// through prep and check to the result register; one that divides also runs
// the 32-step one-bit-per-cycle divider shared by the correction and phase folding
// one transaction is in flight at a time; the result register lets the next
// one be accepted while the previous result waits on out_ready_i
// reset is asynchronous, clears all timer state and loads default config
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_coupled_period_sync_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pcps_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [pcps_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             in_op_i,
  input  wire logic [pcps_pkg::PhaseW-1:0]      in_neighbor_phase_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_flash_o,
  output logic [pcps_pkg::PhaseW-1:0]           out_own_phase_o,
  output logic                                  out_phase_valid_o
);

  pcps_pkg::ctrl_cmd_t    cmd;
  pcps_pkg::ctrl_status_t status;

  pcps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pcps_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_op_i             (in_op_i),
    .in_neighbor_phase_i (in_neighbor_phase_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .flash_o             (out_flash_o),
    .own_phase_o         (out_own_phase_o),
    .phase_valid_o       (out_phase_valid_o)
  );

endmodule

`default_nettype wire
